// ===== rtl/sfa_pkg.sv =====
package sfa_pkg;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_POS_OVF = 3'd1;
  localparam logic [2:0] ST_NEG_OVF = 3'd2;
  localparam logic [2:0] ST_DIV_ZERO = 3'd3;
  localparam logic [2:0] ST_MIN_DIV = 3'd4;

  // Class decided by the front end for each beat.
  typedef enum logic [1:0] {
    CLS_ADDSUB  = 2'd0,
    CLS_MUL     = 2'd1,
    CLS_DIV     = 2'd2,
    CLS_SPECIAL = 2'd3
  } cls_e;

endpackage

// ===== rtl/sfa_front.sv =====
module sfa_front
  import sfa_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       op_i,
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  output logic             q_valid_o,
  input  logic             q_stall_i,
  output logic [1:0]       q_op_o,
  output cls_e             q_cls_o,
  output logic [WIDTH-1:0] q_a_o,
  output logic [WIDTH-1:0] q_b_o,
  output logic [WIDTH-1:0] q_val_o,
  output logic [2:0]       q_st_o
);

  localparam int Depth = 2;

  logic [1:0]       op_q   [Depth];
  cls_e             cls_q  [Depth];
  logic [WIDTH-1:0] a_q    [Depth];
  logic [WIDTH-1:0] b_q    [Depth];
  logic [WIDTH-1:0] val_q  [Depth];
  logic [2:0]       st_q   [Depth];
  logic             wp_q, rp_q;
  logic [1:0]       cnt_q;

  logic             push, pop;
  cls_e             cls_d;
  logic [WIDTH-1:0] val_d;
  logic [2:0]       st_d;
  logic [WIDTH-1:0] max_v, min_v;

  assign max_v = {1'b0, {(WIDTH-1){1'b1}}};
  assign min_v = {1'b1, {(WIDTH-1){1'b0}}};

  // Divide special cases are resolved here and skip the divider entirely.
  always_comb begin
    val_d = '0;
    st_d  = ST_OK;
    case (op_i)
      OP_MUL:  cls_d = CLS_MUL;
      OP_DIV: begin
        cls_d = CLS_DIV;
        if (b_i == '0) begin
          cls_d = CLS_SPECIAL;
          st_d  = ST_DIV_ZERO;
          val_d = (!a_i[WIDTH-1] && a_i != '0) ? max_v : min_v;
        end else if (a_i == min_v && b_i == '1) begin
          cls_d = CLS_SPECIAL;
          st_d  = ST_MIN_DIV;
          val_d = max_v;
        end
      end
      default: cls_d = CLS_ADDSUB;
    endcase
  end

  assign in_stall_o = (cnt_q == 2'(Depth));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_valid_o && !q_stall_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      op_q[wp_q]  <= op_i;
      cls_q[wp_q] <= cls_d;
      a_q[wp_q]   <= a_i;
      b_q[wp_q]   <= b_i;
      val_q[wp_q] <= val_d;
      st_q[wp_q]  <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  assign q_op_o  = op_q[rp_q];
  assign q_cls_o = cls_q[rp_q];
  assign q_a_o   = a_q[rp_q];
  assign q_b_o   = b_q[rp_q];
  assign q_val_o = val_q[rp_q];
  assign q_st_o  = st_q[rp_q];

endmodule

// ===== rtl/sfa_back.sv =====
module sfa_back
  import sfa_pkg::*;
#(
  parameter int WIDTH     = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  output logic             q_stall_o,
  input  logic [1:0]       q_op_i,
  input  cls_e             q_cls_i,
  input  logic [WIDTH-1:0] q_a_i,
  input  logic [WIDTH-1:0] q_b_i,
  input  logic [WIDTH-1:0] q_val_i,
  input  logic [2:0]       q_st_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [WIDTH-1:0] value_o,
  output logic [2:0]       status_o
);

  localparam int NumW = WIDTH + FRAC_BITS;
  localparam int CntW = $clog2(NumW + 1);
  localparam int PW   = 2 * WIDTH;

  // Busy sequencer for multiply (partial products) and divide (one bit a cycle).
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;

  localparam int HW = (WIDTH + 1) / 2;

  logic [1:0]       state_q;
  logic             neg_q;
  logic [WIDTH-1:0] ma_q, mb_q;
  logic [PW-1:0]    prod_q;
  logic             mphase_q;
  logic [NumW-1:0]  num_q;
  logic [NumW-1:0]  quo_q;
  logic [WIDTH:0]   rem_q;
  logic [CntW-1:0]  cnt_q;

  logic             ov_q;
  logic [WIDTH-1:0] value_q;
  logic [2:0]       status_q;

  logic             take, done_ready;
  logic [WIDTH-1:0] ma_d, mb_d, max_v, min_v;
  logic [WIDTH:0]   rem_sh, rem_sub;
  logic [PW-1:0]    pp;
  logic [WIDTH-1:0] res_v;
  logic [2:0]       res_s;
  logic             fin;
  logic [WIDTH:0]   sum_w;
  logic             sum_ovf;

  assign max_v = {1'b0, {(WIDTH-1){1'b1}}};
  assign min_v = {1'b1, {(WIDTH-1){1'b0}}};
  assign ma_d  = q_a_i[WIDTH-1] ? (~q_a_i + 1'b1) : q_a_i;
  assign mb_d  = q_b_i[WIDTH-1] ? (~q_b_i + 1'b1) : q_b_i;

  assign done_ready = !ov_q || !out_stall_i;
  assign take       = q_valid_i && state_q == S_IDLE && done_ready;
  assign q_stall_o  = !(state_q == S_IDLE && done_ready);

  // One half-width partial product per cycle keeps each multiplier narrow.
  // The operands are widened first so that the product keeps all its bits.
  always_comb begin
    if (!mphase_q)
      pp = PW'(ma_q) * PW'(mb_q[HW-1:0]);
    else
      pp = (PW'(ma_q) * PW'(mb_q >> HW)) << HW;
  end

  assign rem_sh  = {rem_q[WIDTH-1:0], num_q[NumW-1]};
  assign rem_sub = rem_sh - {1'b0, mb_q};

  // Saturation of a sign-magnitude result, shared by multiply and divide.
  function automatic void sat_mag(input logic neg, input logic [PW+NumW-1:0] mag,
                                  input logic [WIDTH-1:0] mx,
                                  output logic [WIDTH-1:0] v, output logic [2:0] s);
    logic [PW+NumW-1:0] lim;
    lim = (PW+NumW)'(mx);
    v   = '0;
    s   = ST_OK;
    if (!neg) begin
      if (mag <= lim) v = mag[WIDTH-1:0];
      else begin v = mx; s = ST_POS_OVF; end
    end else begin
      if (mag <= lim + 1'b1) v = ~mag[WIDTH-1:0] + 1'b1;
      else begin v = ~mx; s = ST_NEG_OVF; end
    end
  endfunction

  always_comb begin
    logic [PW-1:0]      full;
    logic [PW-1:0]      shr;
    logic               drop;
    logic [PW+NumW-1:0] mag;
    fin   = 1'b0;
    res_v = '0;
    res_s = ST_OK;
    full  = prod_q + pp;
    shr   = full >> FRAC_BITS;
    drop  = (FRAC_BITS == 0) ? 1'b0 : ((full & ((PW'(1) << FRAC_BITS) - 1'b1)) != '0);
    mag   = '0;
    if (state_q == S_MUL && mphase_q) begin
      fin = 1'b1;
      mag = (PW+NumW)'(shr) + (PW+NumW)'(neg_q && drop);
      sat_mag(neg_q, mag, max_v, res_v, res_s);
    end else if (state_q == S_DIV && cnt_q == CntW'(1)) begin
      fin = 1'b1;
      mag = (PW+NumW)'({quo_q[NumW-2:0], !rem_sub[WIDTH]});
      sat_mag(neg_q, mag, max_v, res_v, res_s);
    end
  end

  always_comb begin
    logic [WIDTH-1:0] bb;
    bb      = (q_op_i == OP_SUB) ? ~q_b_i : q_b_i;
    sum_w   = {q_a_i[WIDTH-1], q_a_i} + {bb[WIDTH-1], bb} + (WIDTH+1)'(q_op_i == OP_SUB);
    sum_ovf = sum_w[WIDTH] != sum_w[WIDTH-1];
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      neg_q    <= q_a_i[WIDTH-1] ^ q_b_i[WIDTH-1];
      ma_q     <= ma_d;
      mb_q     <= mb_d;
      prod_q   <= '0;
      mphase_q <= 1'b0;
      num_q    <= {ma_d, {FRAC_BITS{1'b0}}};
      quo_q    <= '0;
      rem_q    <= '0;
      cnt_q    <= CntW'(NumW);
    end else if (state_q == S_MUL) begin
      prod_q   <= prod_q + pp;
      mphase_q <= 1'b1;
    end else if (state_q == S_DIV) begin
      num_q <= num_q << 1;
      quo_q <= {quo_q[NumW-2:0], !rem_sub[WIDTH]};
      rem_q <= rem_sub[WIDTH] ? rem_sh : rem_sub;
      cnt_q <= cnt_q - CntW'(1);
    end
    if (take && (q_cls_i == CLS_ADDSUB || q_cls_i == CLS_SPECIAL)) begin
      if (q_cls_i == CLS_SPECIAL) begin
        value_q  <= q_val_i;
        status_q <= q_st_i;
      end else if (sum_ovf) begin
        value_q  <= sum_w[WIDTH] ? min_v : max_v;
        status_q <= sum_w[WIDTH] ? ST_NEG_OVF : ST_POS_OVF;
      end else begin
        value_q  <= sum_w[WIDTH-1:0];
        status_q <= ST_OK;
      end
    end else if (fin) begin
      value_q  <= res_v;
      status_q <= res_s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      if (ov_q && !out_stall_i) ov_q <= 1'b0;
      if (take) begin
        case (q_cls_i)
          CLS_MUL: state_q <= S_MUL;
          CLS_DIV: state_q <= S_DIV;
          default: ov_q <= 1'b1;
        endcase
      end else if (fin) begin
        state_q <= S_IDLE;
        ov_q    <= 1'b1;
      end
    end
  end

  assign out_valid_o = ov_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

endmodule

// ===== rtl/saturating_fixed_point_alu.sv =====
// Saturating signed fixed-point ALU: add, subtract, multiply, divide on WIDTH-bit
// words with FRAC_BITS fraction bits; out-of-range results clamp to max or min
// with a status code. Add, subtract and divide special cases are finished as soon
// as the back end takes them and run back to back unless the output is stalled.
// Multiply occupies the back end for two half-width partial products, divide for
// a one-bit-a-cycle restoring divider that forms WIDTH+FRAC_BITS quotient bits.
// Every beat is registered in the queue, and the back end registers its result
// before it is offered at the output. A two-entry queue after the classifying front
// end lets new beats enter while the execution back end is busy.
module saturating_fixed_point_alu
  import sfa_pkg::*;
#(
  parameter int WIDTH     = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       op_i,
  input  logic [WIDTH-1:0] operand_a_i,
  input  logic [WIDTH-1:0] operand_b_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [WIDTH-1:0] value_o,
  output logic [2:0]       status_o
);

  logic             q_valid, q_stall;
  logic [1:0]       q_op;
  cls_e             q_cls;
  logic [WIDTH-1:0] q_a, q_b, q_val;
  logic [2:0]       q_st;

  sfa_front #(.WIDTH(WIDTH)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .op_i,
    .a_i(operand_a_i), .b_i(operand_b_i),
    .q_valid_o(q_valid), .q_stall_i(q_stall), .q_op_o(q_op), .q_cls_o(q_cls),
    .q_a_o(q_a), .q_b_o(q_b), .q_val_o(q_val), .q_st_o(q_st)
  );

  sfa_back #(.WIDTH(WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_stall_o(q_stall), .q_op_i(q_op), .q_cls_i(q_cls),
    .q_a_i(q_a), .q_b_i(q_b), .q_val_i(q_val), .q_st_i(q_st),
    .out_valid_o, .out_stall_i, .value_o, .status_o
  );

endmodule

// ===== rtl/sfa_checker.sv =====
module sfa_checker
  import sfa_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [WIDTH-1:0] value_o,
  input logic [2:0]       status_o
);

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= ST_MIN_DIV) else $error("bad status");

  a_pos_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_POS_OVF || status_o == ST_MIN_DIV)
    |-> value_o == {1'b0, {(WIDTH-1){1'b1}}}) else $error("pos sat value");

  a_neg_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_NEG_OVF
    |-> value_o == {1'b1, {(WIDTH-1){1'b0}}}) else $error("neg sat value");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(value_o))
    else $error("stalled beat changed");

endmodule

bind saturating_fixed_point_alu sfa_checker #(.WIDTH(WIDTH)) u_sfa_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_stall_i, .value_o, .status_o
);
